// ===== design/ycm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Yaw consistency monitor package
// Shared constants, codes, the configuration record and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ycm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CFG_ADDR_W     = 4;
    localparam int CORDIC_STEPS   = 24;
    localparam int CORDIC_W       = 36;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_COV_LIMIT = 2'd1;
    localparam logic [1:0] REG_WARMUP    = 2'd2;

    localparam logic [15:0] THRESHOLD_RST = 16'd1043;
    localparam logic [31:0] COV_LIMIT_RST = 32'd3277;
    localparam logic [7:0]  WARMUP_RST    = 8'd5;

    localparam logic [1:0] OP_ODOM = 2'd0;
    localparam logic [1:0] OP_IMU  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] LV_OK      = 2'd0;
    localparam logic [1:0] LV_WARNING = 2'd1;
    localparam logic [1:0] LV_ERROR   = 2'd2;

    localparam logic [2:0] RS_WAITING      = 3'd0;
    localparam logic [2:0] RS_COV_HIGH     = 3'd1;
    localparam logic [2:0] RS_STABILIZING  = 3'd2;
    localparam logic [2:0] RS_INCONSISTENT = 3'd3;
    localparam logic [2:0] RS_CONSISTENT   = 3'd4;

    typedef struct packed {
        logic [15:0] yaw_threshold;
        logic [31:0] covariance_limit;
        logic [7:0]  warmup_ticks;
    } t_cfg;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/ycm_apb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Yaw consistency monitor configuration registers
// APB-style register file for the threshold, covariance limit and warm-up count.
// ----------------------------------------------------------------------------
module ycm_apb (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ycm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output ycm_pkg::t_cfg                       o_cfg
);
    import ycm_pkg::*;

    t_cfg        r_cfg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yaw_threshold    <= THRESHOLD_RST;
            r_cfg.covariance_limit <= COV_LIMIT_RST;
            r_cfg.warmup_ticks     <= WARMUP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_cfg.yaw_threshold    <= pwdata[15:0];
                REG_COV_LIMIT: r_cfg.covariance_limit <= pwdata;
                REG_WARMUP:    r_cfg.warmup_ticks     <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = {16'd0, r_cfg.yaw_threshold};
            REG_COV_LIMIT: prdata = r_cfg.covariance_limit;
            REG_WARMUP:    prdata = {24'd0, r_cfg.warmup_ticks};
            default:       prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/ycm_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Yaw consistency monitor heading unit
// Forms the quaternion products on one shared multiplier, then, unless the sample is at the
// pole (heading zero), runs an iterative CORDIC vectoring loop to give the heading in binary angle units.
// ----------------------------------------------------------------------------
module ycm_cordic #(
    parameter int ANGLE_BITS = ycm_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [15:0]     i_quat_x,
    input  wire logic signed [15:0]     i_quat_y,
    input  wire logic signed [15:0]     i_quat_z,
    input  wire logic signed [15:0]     i_quat_w,
    output logic                        o_done,
    output logic [ANGLE_BITS-1:0]       o_heading
);
    import ycm_pkg::*;

    localparam int RB = 31 - ANGLE_BITS;
    localparam int DW = CORDIC_W;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MUL  = 3'd1;
    localparam logic [2:0] C_FIN  = 3'd2;
    localparam logic [2:0] C_ROT  = 3'd3;
    localparam logic [2:0] C_RND  = 3'd4;

    localparam logic [2:0] P_XY = 3'd0;
    localparam logic [2:0] P_WZ = 3'd1;
    localparam logic [2:0] P_WW = 3'd2;
    localparam logic [2:0] P_XX = 3'd3;
    localparam logic [2:0] P_YY = 3'd4;
    localparam logic [2:0] P_ZZ = 3'd5;
    localparam logic [2:0] P_XZ = 3'd6;
    localparam logic [2:0] P_WY = 3'd7;

    logic [2:0]             r_state;
    logic [4:0]             r_cnt;
    logic signed [15:0]     r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0]     r_prod;
    logic                   r_pvld;
    logic [2:0]             r_psel;
    logic signed [33:0]     r_num, r_den, r_norm, r_pole;
    logic signed [DW-1:0]   r_cx, r_cy;
    logic [31:0]            r_acc;

    logic signed [15:0]     opa, opb;
    logic signed [33:0]     p_ext;
    logic signed [DW-1:0]   num_w, den_w, norm_w, pole_w, pole_abs;
    logic signed [DW-1:0]   dx, dy;
    logic [31:0]            step_ang;

    always_comb begin
        unique case (r_cnt[2:0])
            P_XY: begin opa = r_qx; opb = r_qy; end
            P_WZ: begin opa = r_qw; opb = r_qz; end
            P_WW: begin opa = r_qw; opb = r_qw; end
            P_XX: begin opa = r_qx; opb = r_qx; end
            P_YY: begin opa = r_qy; opb = r_qy; end
            P_ZZ: begin opa = r_qz; opb = r_qz; end
            P_XZ: begin opa = r_qx; opb = r_qz; end
            P_WY: begin opa = r_qw; opb = r_qy; end
            default: begin opa = r_qx; opb = r_qy; end
        endcase
    end

    assign p_ext    = 34'(r_prod);
    assign num_w    = DW'(r_num) <<< 1;
    assign pole_w   = DW'(r_pole) <<< 1;
    assign den_w    = DW'(r_den);
    assign norm_w   = DW'(r_norm);
    assign pole_abs = (pole_w < 0) ? -pole_w : pole_w;
    assign dx       = r_cy >>> r_cnt;
    assign dy       = r_cx >>> r_cnt;
    assign step_ang = atan_turn(r_cnt);

    assign o_done    = (r_state == C_RND);
    assign o_heading = r_acc[31 -: ANGLE_BITS] + ANGLE_BITS'(r_acc[RB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
            r_pvld  <= 1'b0;
        end else begin
            r_pvld <= (r_state == C_MUL) && !r_cnt[3];
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_MUL;
                        r_cnt   <= '0;
                    end
                end
                C_MUL: begin
                    if (r_cnt[3]) begin
                        r_state <= C_FIN;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                C_FIN: begin
                    r_cnt <= '0;
                    if (pole_abs >= norm_w) begin
                        r_state <= C_RND;
                    end else begin
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= C_RND;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                C_RND: begin
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_qx   <= i_quat_x;
            r_qy   <= i_quat_y;
            r_qz   <= i_quat_z;
            r_qw   <= i_quat_w;
            r_num  <= '0;
            r_den  <= '0;
            r_norm <= '0;
            r_pole <= '0;
        end else if (r_pvld) begin
            case (r_psel)
                P_XY, P_WZ: r_num <= r_num + p_ext;
                P_WW, P_XX: begin
                    r_den  <= r_den + p_ext;
                    r_norm <= r_norm + p_ext;
                end
                P_YY, P_ZZ: begin
                    r_den  <= r_den - p_ext;
                    r_norm <= r_norm + p_ext;
                end
                P_XZ: r_pole <= r_pole + p_ext;
                default: r_pole <= r_pole - p_ext;
            endcase
        end
        if (r_state == C_MUL) begin
            r_prod <= opa * opb;
            r_psel <= r_cnt[2:0];
        end
        if (r_state == C_FIN) begin
            if (pole_abs >= norm_w) begin
                r_acc <= '0;
            end else if (den_w < 0) begin
                if (num_w >= 0) begin
                    r_cx  <= num_w;
                    r_cy  <= -den_w;
                    r_acc <= 32'h4000_0000;
                end else begin
                    r_cx  <= -num_w;
                    r_cy  <= den_w;
                    r_acc <= 32'hC000_0000;
                end
            end else begin
                r_cx  <= den_w;
                r_cy  <= num_w;
                r_acc <= '0;
            end
        end else if (r_state == C_ROT) begin
            if (r_cy > 0) begin
                r_cx  <= r_cx + dx;
                r_cy  <= r_cy - dy;
                r_acc <= r_acc + step_ang;
            end else begin
                r_cx  <= r_cx - dx;
                r_cy  <= r_cy + dy;
                r_acc <= r_acc - step_ang;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/yaw_consistency_monitor.sv =====
// A sample request passes through an accept step, the products on the shared
// multiplier, a setup step, the CORDIC iterations, a rounding step and a step to
// refresh the stored heading difference. A sample at the pole skips the iterations.
// A tick request's result is registered and valid the next cycle.
// Synchronous active-low reset restores register defaults and clears control state.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Yaw consistency monitor
// Stores odometry and IMU headings; ticks check their wrapped, offset-corrected gap.
// ----------------------------------------------------------------------------
module yaw_consistency_monitor #(
    parameter int ANGLE_BITS = ycm_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic signed [15:0]             i_quat_x,
    input  wire logic signed [15:0]             i_quat_y,
    input  wire logic signed [15:0]             i_quat_z,
    input  wire logic signed [15:0]             i_quat_w,
    input  wire logic signed [31:0]             i_yaw_variance,
    input  wire logic signed [31:0]             i_stamp_seconds,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_level,
    output logic [2:0]                          o_reason,
    output logic [15:0]                         o_yaw_difference,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ycm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import ycm_pkg::*;

    localparam int CW = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_DIFF = 2'd2;

    t_cfg                   cfg;
    logic [1:0]             r_state;
    logic                   r_is_odom;
    logic                   r_odom_seen, r_imu_seen;
    logic [ANGLE_BITS-1:0]  r_odom_heading, r_imu_heading, r_diff, r_offset;
    logic [31:0]            r_odom_var, r_imu_var, r_last_stamp;
    logic                   r_offset_latched;
    logic [7:0]             r_tick_count;
    logic                   r_out_valid;
    logic [1:0]             r_level;
    logic [2:0]             r_reason;
    logic [15:0]            r_ydiff;

    logic                   accept, start, cordic_done;
    logic [ANGLE_BITS-1:0]  cordic_heading;
    logic [7:0]             n_tick_count;
    logic [ANGLE_BITS-1:0]  d_live, mag;
    logic [CW-1:0]          mag_w, thr_w;
    logic                   both_seen, cov_high, warming;
    logic [1:0]             tick_level;
    logic [2:0]             tick_reason;
    logic [15:0]            tick_ydiff;

    ycm_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ycm_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .o_done    (cordic_done),
        .o_heading (cordic_heading)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign start      = accept && (i_opcode == OP_ODOM || i_opcode == OP_IMU);

    assign o_out_valid      = r_out_valid;
    assign o_level          = r_level;
    assign o_reason         = r_reason;
    assign o_yaw_difference = r_ydiff;

    always_comb begin
        n_tick_count = (r_tick_count == 8'hFF) ? r_tick_count : r_tick_count + 8'd1;
        both_seen    = r_odom_seen && r_imu_seen;
        cov_high     = ($signed(r_odom_var) > $signed(cfg.covariance_limit)) ||
                       ($signed(r_imu_var) > $signed(cfg.covariance_limit));
        warming      = n_tick_count < cfg.warmup_ticks;
        d_live       = r_offset_latched ? (r_diff - r_offset) : '0;
        mag          = (d_live > HALF_TURN) ? ('0 - d_live) : d_live;
        mag_w        = CW'(mag);
        thr_w        = CW'(cfg.yaw_threshold);
        tick_ydiff   = 16'd0;
        if (!both_seen) begin
            tick_level  = LV_WARNING;
            tick_reason = RS_WAITING;
        end else if (cov_high) begin
            tick_level  = LV_ERROR;
            tick_reason = RS_COV_HIGH;
        end else if (warming) begin
            tick_level  = LV_WARNING;
            tick_reason = RS_STABILIZING;
        end else begin
            tick_ydiff = mag_w[15:0];
            if (mag_w > thr_w) begin
                tick_level  = LV_ERROR;
                tick_reason = RS_INCONSISTENT;
            end else begin
                tick_level  = LV_OK;
                tick_reason = RS_CONSISTENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_is_odom        <= 1'b0;
            r_odom_seen      <= 1'b0;
            r_imu_seen       <= 1'b0;
            r_odom_heading   <= '0;
            r_imu_heading    <= '0;
            r_diff           <= '0;
            r_offset         <= '0;
            r_odom_var       <= '0;
            r_imu_var        <= '0;
            r_last_stamp     <= '0;
            r_offset_latched <= 1'b0;
            r_tick_count     <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept && (i_opcode == OP_TICK)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_opcode)
                            OP_ODOM: begin
                                if (r_odom_seen && (i_stamp_seconds < $signed(r_last_stamp))) begin
                                    r_offset_latched <= 1'b0;
                                end
                                r_last_stamp <= i_stamp_seconds;
                                r_odom_var   <= i_yaw_variance;
                                r_is_odom    <= 1'b1;
                                r_state      <= S_BUSY;
                            end
                            OP_IMU: begin
                                r_imu_var <= i_yaw_variance;
                                r_is_odom <= 1'b0;
                                r_state   <= S_BUSY;
                            end
                            OP_TICK: begin
                                if (both_seen && !cov_high) begin
                                    r_tick_count <= n_tick_count;
                                    if (!warming && !r_offset_latched) begin
                                        r_offset         <= r_diff;
                                        r_offset_latched <= 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_BUSY: begin
                    if (cordic_done) begin
                        if (r_is_odom) begin
                            r_odom_heading <= cordic_heading;
                            r_odom_seen    <= 1'b1;
                        end else begin
                            r_imu_heading <= cordic_heading;
                            r_imu_seen    <= 1'b1;
                        end
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_diff  <= r_imu_heading - r_odom_heading;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_TICK) begin
            r_level  <= tick_level;
            r_reason <= tick_reason;
            r_ydiff  <= tick_ydiff;
        end
    end

endmodule
`default_nettype wire

// ===== design/ycm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Yaw consistency monitor port checker
// Watches the top-level ports for result coding, output hold, request pacing and configuration-port rules.
// ----------------------------------------------------------------------------
module ycm_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic [1:0]                     i_opcode,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [1:0]                     o_level,
    input wire logic [2:0]                     o_reason,
    input wire logic [15:0]                    o_yaw_difference,
    input wire logic                           pready
);
    import ycm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_level) &&
        $stable(o_reason) && $stable(o_yaw_difference))
        else $error("Result changed while stalled.");

    a_level_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_reason == RS_WAITING || o_reason == RS_STABILIZING) && o_level == LV_WARNING) ||
        ((o_reason == RS_COV_HIGH || o_reason == RS_INCONSISTENT) && o_level == LV_ERROR) ||
        (o_reason == RS_CONSISTENT && o_level == LV_OK))
        else $error("Level does not match reason.");

    a_diff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_reason == RS_WAITING || o_reason == RS_COV_HIGH ||
        o_reason == RS_STABILIZING) |-> o_yaw_difference == 16'd0)
        else $error("Difference reported without a comparison.");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_ODOM || i_opcode == OP_IMU)
        |=> !o_in_ready)
        else $error("Ready while a sample request is being processed.");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("Configuration port stalled.");

endmodule

bind yaw_consistency_monitor ycm_checker u_ycm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_opcode         (i_opcode),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_level          (o_level),
    .o_reason         (o_reason),
    .o_yaw_difference (o_yaw_difference),
    .pready           (pready)
);
`default_nettype wire
